FILE: rtl/core/plob_pkg.sv
// shared types and constants for the price level order book
`timescale 1ns / 1ps
package plob_pkg;
    localparam int ORDER_SLOTS = 1024;
    localparam int LEVEL_SLOTS = 64;
    localparam int PRICE_BITS  = 32;
    localparam int ID_W        = 10;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_MODIFY = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // command broadcast along the level chain
    typedef struct packed {
        logic                  en;
        logic [PRICE_BITS-1:0] price;
        logic signed [33:0]    delta;
    } lvl_cmd_t;

    // per-cell view handed to neighbors
    typedef struct packed {
        logic                  occ;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           total;
    } lvl_cell_t;
endpackage

FILE: rtl/core/plob_cell.sv
// one price level cell of a sorted chain
`timescale 1ns / 1ps
module plob_cell import plob_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  side,
    input  lvl_cmd_t              cmd,
    input  lvl_cell_t             left_in,
    input  logic                  left_better,
    input  lvl_cell_t             right_in,
    input  logic                  del_any,
    input  logic                  grow,
    output lvl_cell_t             cell_out,
    output logic                  better_out,
    output logic                  here_out,
    output logic                  del_out,
    output logic                  ovf_out
);
    logic occ_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [31:0] total_reg;
    logic better, here, sat_hi;
    logic signed [34:0] t;

    // price strictly better than the new one (cell stays in place)
    assign better = occ_reg && (side ? (price_reg < cmd.price) : (price_reg > cmd.price));
    assign here   = occ_reg && (price_reg == cmd.price);
    assign t = $signed({3'b000, total_reg}) + 35'(cmd.delta);
    assign sat_hi = t > 35'sh0FFFFFFFF;
    assign better_out = better;
    assign here_out   = here;
    assign del_out    = here && (t <= 0);
    assign ovf_out    = here && sat_hi;
    assign cell_out = '{occ: occ_reg, price: price_reg, total: total_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else if (cmd.en) begin
            if (del_any && !better) begin
                // deleted cell and everything behind it move one step left
                occ_reg   <= right_in.occ;
                price_reg <= right_in.price;
                total_reg <= right_in.total;
            end else if (here) begin
                total_reg <= sat_hi ? 32'hFFFFFFFF : t[31:0];
            end else if (grow && left_better && !better) begin
                occ_reg   <= 1'b1;
                price_reg <= cmd.price;
                total_reg <= (cmd.delta > 34'sh0FFFFFFFF) ? 32'hFFFFFFFF
                                                          : cmd.delta[31:0];
            end else if (grow && !left_better) begin
                // behind the insertion point, move one step right
                occ_reg   <= left_in.occ;
                price_reg <= left_in.price;
                total_reg <= left_in.total;
            end
        end
    end
endmodule

FILE: rtl/core/plob_chain.sv
// sorted level chain for one side of the book
`timescale 1ns / 1ps
module plob_chain import plob_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  side,
    input  lvl_cmd_t              cmd,
    input  logic [5:0]            rd_idx,
    output lvl_cell_t             rd_cell,
    output logic                  hit,
    output logic                  full,
    output logic                  ovf
);
    lvl_cell_t cells [LEVEL_SLOTS];
    logic [LEVEL_SLOTS-1:0] better_v;
    logic [LEVEL_SLOTS-1:0] here_v;
    logic [LEVEL_SLOTS-1:0] del_v;
    logic [LEVEL_SLOTS-1:0] ovf_v;
    logic del_any, grow;
    lvl_cell_t empty_c;
    assign empty_c = '{occ: 1'b0, price: '0, total: '0};
    assign hit     = |here_v;
    assign del_any = |del_v;
    assign ovf     = |ovf_v;
    assign full    = cells[LEVEL_SLOTS-1].occ;
    // a new level only when the price is absent, room is left and the amount is positive
    assign grow    = !hit && !full && (cmd.delta > 0);

    genvar g;
    generate
        for (g = 0; g < LEVEL_SLOTS; g++) begin : g_cell
            plob_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .side(side), .cmd(cmd),
                .left_in(g == 0 ? empty_c : cells[(g == 0) ? 0 : g-1]),
                .left_better(g == 0 ? 1'b1 : better_v[(g == 0) ? 0 : g-1]),
                .right_in(g == LEVEL_SLOTS-1 ? empty_c : cells[(g == LEVEL_SLOTS-1) ? g : g+1]),
                .del_any(del_any), .grow(grow),
                .cell_out(cells[g]), .better_out(better_v[g]),
                .here_out(here_v[g]), .del_out(del_v[g]), .ovf_out(ovf_v[g]));
        end
    endgenerate
    assign rd_cell = cells[rd_idx];
endmodule

FILE: rtl/core/price_level_order_book_top.sv
// top level of the price level order book
//  channel | dir | handshake       | fields
//  s_      | in  | s_valid/s_ready | func ord_id side price size level
//  m_      | out | m_valid/m_ready | status level_price level_size
// each transaction is accepted with the order table read, then its execute state
//   updates a chain and loads the result register
// the input takes no new transaction until the last one has executed
// reset (aresetn, synchronous) empties both chains and starts a clearing pass over
//   all 1024 order table entries; s_ready stays low until it ends
// a held result stalls the next transaction in its execute state, nothing else waits
`timescale 1ns / 1ps
module price_level_order_book_top import plob_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [9:0]  s_ord_id,
    input  logic        s_side,
    input  logic [31:0] s_price,
    input  logic [30:0] s_size,
    input  logic [6:0]  s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_level_price,
    output logic [31:0] m_level_size
);
    localparam logic [1:0] S_CLR = 2'd0, S_IDLE = 2'd1, S_EXEC = 2'd2;
    logic [1:0] state_reg;
    logic [ID_W-1:0] clr_reg;
    logic [64:0] omem [ORDER_SLOTS];
    logic [64:0] ord_reg;
    logic [1:0] func_reg; logic [ID_W-1:0] id_reg; logic side_reg;
    logic [31:0] price_reg; logic [30:0] size_reg; logic [6:0] level_reg;
    logic m_valid_reg;
    logic was_valid, fire, go;
    lvl_cmd_t bcmd, acmd;
    lvl_cell_t bcell, acell, qc;
    logic bhit, ahit, bfull, afull, bovf, aovf, eside, ehit, efull, eovf;
    logic [31:0] eprice;
    logic [30:0] newsz;
    logic signed [33:0] edelta;
    logic [2:0] st;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    // execute goes ahead once the result register is free or being emptied
    assign fire = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign was_valid = ord_reg[64];

    // order table memory: {valid, side, price, size}
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) ord_reg <= omem[s_ord_id];
        if (state_reg == S_CLR) begin
            omem[clr_reg] <= '0;
        end else if (fire && func_reg != FUNC_QUERY) begin
            if (func_reg == FUNC_ADD) begin
                // an existing id keeps its old record
                if (!was_valid) omem[id_reg] <= {1'b1, side_reg, price_reg, size_reg};
            end else if (was_valid) begin
                omem[id_reg] <= {func_reg != FUNC_REMOVE, ord_reg[63:31], newsz};
            end
        end
    end

    // add works on the given side and price, modify and remove on the stored ones
    assign newsz  = (func_reg == FUNC_REMOVE) ? 31'd0 : size_reg;
    assign eside  = (func_reg == FUNC_ADD) ? side_reg : ord_reg[63];
    assign eprice = (func_reg == FUNC_ADD) ? price_reg : ord_reg[62:31];
    assign edelta = (func_reg == FUNC_ADD) ? $signed({3'b000, size_reg}) :
                    $signed({3'b000, newsz}) - $signed({3'b000, ord_reg[30:0]});
    assign go = fire && func_reg != FUNC_QUERY && (func_reg == FUNC_ADD || was_valid);
    assign bcmd = '{en: go && !eside, price: eprice, delta: edelta};
    assign acmd = '{en: go &&  eside, price: eprice, delta: edelta};

    plob_chain u_bid (.aclk(aclk), .aresetn(aresetn), .side(1'b0), .cmd(bcmd),
        .rd_idx(level_reg[5:0] - 6'd1), .rd_cell(bcell), .hit(bhit), .full(bfull),
        .ovf(bovf));
    plob_chain u_ask (.aclk(aclk), .aresetn(aresetn), .side(1'b1), .cmd(acmd),
        .rd_idx(level_reg[5:0] - 6'd1), .rd_cell(acell), .hit(ahit), .full(afull),
        .ovf(aovf));

    assign ehit  = eside ? ahit : bhit;
    assign efull = eside ? afull : bfull;
    assign eovf  = eside ? aovf : bovf;
    assign qc    = side_reg ? acell : bcell;

    always_comb begin
        st = ST_OK;
        if (func_reg == FUNC_QUERY) begin
            // levels fill from the front, so an empty cell means past the count
            if (level_reg == 7'd0 || level_reg > 7'(LEVEL_SLOTS) || !qc.occ) st = ST_RANGE;
        end else if (func_reg != FUNC_ADD && !was_valid) begin
            st = ST_NOT_FOUND;
        end else if (eovf) begin
            st = ST_FULL;
        end else if (!ehit && edelta > 0 && efull) begin
            st = ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ID_W'(ORDER_SLOTS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_valid) begin
                    state_reg <= S_EXEC;
                    func_reg <= s_func; id_reg <= s_ord_id; side_reg <= s_side;
                    price_reg <= s_price; size_reg <= s_size; level_reg <= s_level;
                end
                S_EXEC: if (fire) begin
                    state_reg <= S_IDLE;
                    m_status <= st;
                    m_level_price <= (func_reg == FUNC_QUERY && st == ST_OK) ? qc.price : '0;
                    m_level_size  <= (func_reg == FUNC_QUERY && st == ST_OK) ? qc.total : '0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/plob_checker.sv
// port-level checks for the price level order book
`timescale 1ns / 1ps
module plob_checker import plob_pkg::*; (
    input logic aclk, input logic aresetn,
    input logic s_valid, input logic s_ready,
    input logic m_valid, input logic m_ready,
    input logic [2:0] m_status, input logic [31:0] m_level_price,
    input logic [31:0] m_level_size
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_level_price)
            && $stable(m_level_size)) else $error("result dropped or changed");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready) else $error("ready dropped without transaction");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_level_price == 32'd0 && m_level_size == 32'd0)
        else $error("level fields not zero");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");
endmodule

bind price_level_order_book_top plob_checker u_chk (.*);

FILE: test/price_level_order_book_top_test.sv
// self-checking testbench for the price level order book top level
`timescale 1ns / 1ps
module price_level_order_book_top_test;
    import plob_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [9:0]  s_ord_id;
    logic        s_side;
    logic [31:0] s_price;
    logic [30:0] s_size;
    logic [6:0]  s_level;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_level_price;
    logic [31:0] m_level_size;

    price_level_order_book_top dut (.*);

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // expected query answer for one transaction
    typedef struct {
        logic [2:0]  status;
        logic [31:0] lprice;
        logic [31:0] lsize;
    } book_answer_t;

    book_answer_t answer_q[$];
    int           mismatch_cnt = 0;

    // shadow copy of the book
    bit          shadow_valid[ORDER_SLOTS];
    bit          shadow_side[ORDER_SLOTS];
    logic [31:0] shadow_price[ORDER_SLOTS];
    logic [30:0] shadow_size[ORDER_SLOTS];
    logic [31:0] lvl_price[2][$];
    logic [31:0] lvl_total[2][$];

    // idle controls
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int hold_req    = 0;
    int hold_ack    = 0;
    int snk_hold    = 0;

    // apply a signed change to one side's level at a price, return status
    function automatic logic [2:0] shift_level(bit sd, logic [31:0] px, longint delta);
        int     i;
        int     n;
        longint t;
        n = lvl_price[sd].size();
        i = 0;
        // bids descend, asks ascend
        while (i < n && (sd ? (lvl_price[sd][i] < px) : (lvl_price[sd][i] > px)))
            i++;
        if (i < n && lvl_price[sd][i] == px) begin
            t = longint'(lvl_total[sd][i]) + delta;
            if (t <= 0) begin
                lvl_price[sd].delete(i);
                lvl_total[sd].delete(i);
                return ST_OK;
            end
            if (t > 64'hFFFF_FFFF) begin
                lvl_total[sd][i] = 32'hFFFF_FFFF;
                return ST_FULL;
            end
            lvl_total[sd][i] = t[31:0];
            return ST_OK;
        end
        if (delta <= 0) return ST_OK;
        if (n >= LEVEL_SLOTS) return ST_FULL;
        lvl_price[sd].insert(i, px);
        lvl_total[sd].insert(i, delta[31:0]);
        return ST_OK;
    endfunction

    // predict the answer to one transaction and update the shadow book
    function automatic book_answer_t predict_book(logic [1:0] fn, logic [9:0] id, bit sd,
            logic [31:0] px, logic [30:0] sz, logic [6:0] lv);
        book_answer_t a;
        logic [30:0]  newsz;
        a = '{ST_OK, 32'd0, 32'd0};
        if (fn == FUNC_QUERY) begin
            if (lv == 0 || lv > lvl_price[sd].size()) begin
                a.status = ST_RANGE;
            end else begin
                a.lprice = lvl_price[sd][lv-1];
                a.lsize  = lvl_total[sd][lv-1];
            end
        end else if (fn == FUNC_ADD) begin
            a.status = shift_level(sd, px, longint'(sz));
            if (!shadow_valid[id]) begin
                shadow_valid[id] = 1'b1;
                shadow_side[id]  = sd;
                shadow_price[id] = px;
                shadow_size[id]  = sz;
            end
        end else if (!shadow_valid[id]) begin
            a.status = ST_NOT_FOUND;
        end else begin
            newsz = (fn == FUNC_REMOVE) ? 31'd0 : sz;
            a.status = shift_level(shadow_side[id], shadow_price[id],
                                   longint'(newsz) - longint'(shadow_size[id]));
            shadow_size[id] = newsz;
            if (fn == FUNC_REMOVE) shadow_valid[id] = 1'b0;
        end
        return a;
    endfunction

    // send one transaction, idling in random bursts first
    task automatic send_order(logic [1:0] fn, logic [9:0] id, bit sd,
            logic [31:0] px, logic [30:0] sz, logic [6:0] lv);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= fn;
        s_ord_id   <= id;
        s_side     <= sd;
        s_price    <= px;
        s_size     <= sz;
        s_level    <= lv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        answer_q.push_back(predict_book(fn, id, sd, px, sz, lv));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answer_q.size() != 0) @(posedge aclk);
    endtask

    // receiver side: random stall bursts, plus a requested long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            snk_hold <= 59;
            m_ready  <= 1'b0;
        end else if (snk_hold > 0) begin
            snk_hold <= snk_hold - 1;
            m_ready  <= 1'b0;
        end else if (snk_idle_en && m_ready && $urandom_range(0, 5) == 0) begin
            snk_hold <= $urandom_range(0, 7);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        book_answer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected transaction status %0d", $time, m_status);
                mismatch_cnt++;
            end else begin
                e = answer_q.pop_front();
                if (m_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, m_status);
                    mismatch_cnt++;
                end
                if (m_level_price !== e.lprice) begin
                    $display("%0t: level_price expected %0h actual %0h",
                             $time, e.lprice, m_level_price);
                    mismatch_cnt++;
                end
                if (m_level_size !== e.lsize) begin
                    $display("%0t: level_size expected %0h actual %0h",
                             $time, e.lsize, m_level_size);
                    mismatch_cnt++;
                end
            end
        end
    end

    // directed extremes and special cases
    task automatic test_directed();
        send_order(FUNC_QUERY, 0, 0, 0, 0, 1);                  // empty book
        send_order(FUNC_MODIFY, 5, 0, 0, 9, 0);                 // unknown id
        send_order(FUNC_REMOVE, 1023, 1, 0, 0, 0);              // unknown id
        send_order(FUNC_ADD, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        send_order(FUNC_ADD, 1, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        send_order(FUNC_ADD, 2, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0); // saturates
        send_order(FUNC_ADD, 0, 0, 32'hFFFF_FFFF, 5, 0);        // existing id
        send_order(FUNC_ADD, 1023, 1, 0, 1, 0);
        send_order(FUNC_ADD, 3, 1, 10, 0, 0);                   // zero size add
        send_order(FUNC_QUERY, 0, 0, 0, 0, 1);
        send_order(FUNC_QUERY, 0, 1, 0, 0, 1);
        send_order(FUNC_QUERY, 0, 0, 0, 0, 0);                  // level zero
        send_order(FUNC_QUERY, 0, 1, 0, 0, 127);
        send_order(FUNC_MODIFY, 3, 0, 0, 7, 0);                 // creates level
        send_order(FUNC_MODIFY, 1023, 0, 0, 0, 0);              // drops to zero
        send_order(FUNC_REMOVE, 0, 0, 0, 0, 0);
        send_order(FUNC_REMOVE, 1, 0, 0, 0, 0);
        send_order(FUNC_REMOVE, 2, 0, 0, 0, 0);
        send_order(FUNC_REMOVE, 3, 0, 0, 0, 0);
        send_order(FUNC_QUERY, 0, 1, 0, 0, 1);
        wait_drained();
    endtask

    // fill the bid side past 64 levels so the table reports full
    task automatic test_table_full();
        for (int i = 0; i < 70; i++)
            send_order(FUNC_ADD, 10'(100 + i), 0, 32'(1000 + i), 31'd3, 0);
        send_order(FUNC_QUERY, 0, 0, 0, 0, 64);
        send_order(FUNC_QUERY, 0, 0, 0, 0, 65);
        for (int i = 0; i < 70; i++)
            send_order(FUNC_REMOVE, 10'(100 + i), 0, 0, 0, 0);
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 20; i++)
            send_order(FUNC_QUERY, 0, i[0], 0, 0, 7'(i % 3));
        wait_drained();
    endtask

    // random traffic, mostly on a small pool of ids and prices
    task automatic test_random(int n);
        logic [1:0]  fn;
        logic [9:0]  id;
        logic [31:0] px;
        logic [30:0] sz;
        for (int i = 0; i < n; i++) begin
            fn = 2'($urandom_range(0, 3));
            id = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
            px = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(90, 130));
            case ($urandom_range(0, 9))
                0:       sz = 31'($urandom);
                1:       sz = 31'h7FFF_FFFF;
                2:       sz = 31'd0;
                default: sz = 31'($urandom_range(1, 500));
            endcase
            if (i > n - 150) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            send_order(fn, id, 1'($urandom_range(0, 1)), px, sz, 7'($urandom_range(0, 70)));
        end
        wait_drained();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_func     = FUNC_ADD;
        s_ord_id   = '0;
        s_side     = 1'b0;
        s_price    = '0;
        s_size     = '0;
        s_level    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(1370);
        // latency settle
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // timeout
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
